### design/multi_click_button_detector_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the multi-click button detector checker
// Each macro expands to one labeled concurrent assertion clocked on aclk.
// ----------------------------------------------------------------------------
`ifndef MULTI_CLICK_BUTTON_DETECTOR_ASSERT_SVH
`define MULTI_CLICK_BUTTON_DETECTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define MCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define MCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/mcb_pkg.sv
// ----------------------------------------------------------------------------
// mcb_pkg
// Shared types, constants and helpers of the multi-click button detector.
// ----------------------------------------------------------------------------
`default_nettype none

package mcb_pkg;

    localparam int SLOTS_DEF  = 5;
    localparam int FIFO_DEPTH = 6;

    // Register indexes (byte address / 4)
    localparam logic [2:0] REG_TICK_PERIOD = 3'd0;
    localparam logic [2:0] REG_DEAD_TIME   = 3'd1;
    localparam logic [2:0] REG_IDLE_FLUSH  = 3'd2;
    localparam logic [2:0] REG_CLICK_MIN   = 3'd3;
    localparam logic [2:0] REG_CLICK_MAX   = 3'd4;
    localparam logic [2:0] REG_ACTION_MASK = 3'd5;

    // Reset values
    localparam int TICK_PERIOD_RST = 10000;
    localparam int DEAD_TIME_RST   = 50000;
    localparam int IDLE_FLUSH_RST  = 500000;
    localparam int CLICK_MIN_RST   = 100;
    localparam int CLICK_MAX_RST   = 250;
    localparam int ACTION_MASK_RST = 0;

    localparam int US_PER_MS = 1000;
    localparam int TICK_RST_Q = TICK_PERIOD_RST / US_PER_MS;
    localparam int TICK_RST_R = TICK_PERIOD_RST % US_PER_MS;
    localparam int DEAD_RST_Q = DEAD_TIME_RST / US_PER_MS;
    localparam int DEAD_RST_R = DEAD_TIME_RST % US_PER_MS;

    typedef enum logic [1:0] {
        EV_PRESS  = 2'd0,
        EV_CLICKS = 2'd1,
        EV_DONE   = 2'd2
    } event_kind_t;

    typedef struct packed {
        logic        last;
        logic        fire;
        logic [2:0]  count;
        event_kind_t kind;
    } result_t;

    // Microseconds split into whole milliseconds and remainder
    typedef struct packed {
        logic [10:0] q;
        logic [9:0]  r;
    } ms_split_t;

    // x / 1000 by reciprocal multiply: 1073742 = ceil(2^30 / 1000) is exact
    // for every 20-bit x. Remainder via x - q*(1024 - 16 - 8).
    function automatic ms_split_t split_us(input logic [19:0] x);
        logic [40:0] prod;
        logic [19:0] q_ext;
        logic [19:0] rem;
        ms_split_t   res;
        prod  = {21'd0, x} * 41'd1073742;
        q_ext = {9'd0, prod[40:30]};
        rem   = x - ((q_ext << 10) - (q_ext << 4) - (q_ext << 3));
        res.q = prod[40:30];
        res.r = rem[9:0];
        return res;
    endfunction

endpackage

`default_nettype wire

### design/multi_click_button_detector.sv
// ----------------------------------------------------------------------------
// multi_click_button_detector
// Counts multi-clicks on an active-low push button sampled once per poll beat.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload
//  --------+-----+--------------------+--------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tdata[0] pin_level
//  m_      | out | m_tvalid/m_tready  | m_tdata kind/count/fire, m_tlast
//  apb     | in  | psel/penable/pready| six config registers at 4*i
//
//  One poll beat is taken per cycle while s_tready is high. It is held in
//  the input register, then its results (zero, one or two beats) are
//  pushed into a six-entry result queue that drains one beat per cycle
//  while m_tready is high. s_tready drops only when the queue could overflow:
//  queue fill plus two beats per item still in flight must stay within four.
//  Reset (synchronous, aresetn low) clears timers, ring, queue and restores
//  register defaults; no clearing pass is needed.
//  Press time is kept as milliseconds plus a sub-millisecond remainder so
//  the stored length needs no divider; tick and dead time are split into
//  the same form when written.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_click_button_detector
    import mcb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] pin_level, [7:1] zero
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // [1:0] event_kind, [4:2] click_count,
                                        // [5] action_fire, [7:6] zero
    output logic             m_tlast,   // last_result
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W   = $clog2(SLOTS + 1);
    localparam int FPTR_W  = $clog2(FIFO_DEPTH);
    localparam int FCNT_W  = $clog2(FIFO_DEPTH + 1);
    localparam int RDY_LIM = FIFO_DEPTH - 2;
    localparam int MS_W    = 17;                  // saturates well above 65535 ms
    localparam int IDLE_W  = 25;                  // saturates above any flush limit

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [19:0] tick_period_reg;
    logic [19:0] dead_time_reg;
    logic [23:0] idle_flush_reg;
    logic [15:0] click_min_reg;
    logic [15:0] click_max_reg;
    logic [4:0]  action_mask_reg;
    logic [10:0] tick_q_reg;
    logic [9:0]  tick_r_reg;
    logic [10:0] dead_q_reg;
    logic [9:0]  dead_r_reg;

    logic        cfg_wr;
    logic [2:0]  cfg_idx;
    ms_split_t   wr_split;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign cfg_idx  = paddr[4:2];
    assign wr_split = split_us(pwdata[19:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_period_reg <= 20'(TICK_PERIOD_RST);
            dead_time_reg   <= 20'(DEAD_TIME_RST);
            idle_flush_reg  <= 24'(IDLE_FLUSH_RST);
            click_min_reg   <= 16'(CLICK_MIN_RST);
            click_max_reg   <= 16'(CLICK_MAX_RST);
            action_mask_reg <= 5'(ACTION_MASK_RST);
            tick_q_reg      <= 11'(TICK_RST_Q);
            tick_r_reg      <= 10'(TICK_RST_R);
            dead_q_reg      <= 11'(DEAD_RST_Q);
            dead_r_reg      <= 10'(DEAD_RST_R);
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TICK_PERIOD: begin
                    tick_period_reg <= pwdata[19:0];
                    tick_q_reg      <= wr_split.q;
                    tick_r_reg      <= wr_split.r;
                end
                REG_DEAD_TIME: begin
                    dead_time_reg <= pwdata[19:0];
                    dead_q_reg    <= wr_split.q;
                    dead_r_reg    <= wr_split.r;
                end
                REG_IDLE_FLUSH:  idle_flush_reg  <= pwdata[23:0];
                REG_CLICK_MIN:   click_min_reg   <= pwdata[15:0];
                REG_CLICK_MAX:   click_max_reg   <= pwdata[15:0];
                REG_ACTION_MASK: action_mask_reg <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_TICK_PERIOD: prdata = {12'd0, tick_period_reg};
            REG_DEAD_TIME:   prdata = {12'd0, dead_time_reg};
            REG_IDLE_FLUSH:  prdata = {8'd0, idle_flush_reg};
            REG_CLICK_MIN:   prdata = {16'd0, click_min_reg};
            REG_CLICK_MAX:   prdata = {16'd0, click_max_reg};
            REG_ACTION_MASK: prdata = {27'd0, action_mask_reg};
            default:         prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic in_valid_reg;
    logic in_level_reg;
    logic s_accept;

    logic [FCNT_W-1:0] fifo_cnt_reg;
    logic [FCNT_W:0]   fill_bound;

    // Reserve two queue entries for the beat in the input register
    assign fill_bound = {1'b0, fifo_cnt_reg} + (in_valid_reg ? (FCNT_W+1)'(2) : '0);
    assign s_tready   = (fill_bound <= (FCNT_W+1)'(RDY_LIM));
    assign s_accept   = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_level_reg <= s_tdata[0];
        end
    end

    // ------------------------------------------------------------------
    // Detector state
    // ------------------------------------------------------------------
    logic              last_level_reg, last_level_next;
    logic [MS_W-1:0]   press_ms_reg, press_ms_next;
    logic [9:0]        press_rem_reg, press_rem_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic [15:0]       slot_reg [SLOTS];
    logic [15:0]       slot_next [SLOTS];
    logic [SLOT_W-1:0] wslot_reg, wslot_next;

    // Saturating press timer advance
    logic [10:0]       rem_sum;
    logic              rem_carry;
    logic [9:0]        rem_add;
    logic [MS_W:0]     ms_sum;
    logic [MS_W-1:0]   ms_add;
    logic [IDLE_W:0]   idle_sum;
    logic [IDLE_W-1:0] idle_add;
    logic              press_zero;
    logic              in_dead;
    logic [15:0]       press_len;

    assign rem_sum   = {1'b0, press_rem_reg} + {1'b0, tick_r_reg};
    assign rem_carry = (rem_sum >= 11'(US_PER_MS));
    assign rem_add   = rem_carry ? 10'(rem_sum - 11'(US_PER_MS)) : rem_sum[9:0];
    assign ms_sum    = {1'b0, press_ms_reg} + (MS_W+1)'(tick_q_reg) + (MS_W+1)'(rem_carry);
    assign ms_add    = ms_sum[MS_W] ? '1 : ms_sum[MS_W-1:0];
    assign idle_sum  = {1'b0, idle_reg} + (IDLE_W+1)'(tick_period_reg);
    assign idle_add  = idle_sum[IDLE_W] ? '1 : idle_sum[IDLE_W-1:0];

    assign press_zero = (press_ms_reg == '0) && (press_rem_reg == '0);
    assign in_dead    = !last_level_reg &&
                        ((press_ms_reg < MS_W'(dead_q_reg)) ||
                         ((press_ms_reg == MS_W'(dead_q_reg)) && (press_rem_reg < dead_r_reg)));
    assign press_len  = (press_ms_reg > MS_W'(16'hFFFF)) ? 16'hFFFF : press_ms_reg[15:0];

    // Results of the current beat
    result_t           res0, res1;
    logic [1:0]        n_res;
    logic [CNT_W-1:0]  click_cnt;
    logic              flush;
    logic              press_push;
    logic [7:0]        mask_ext;
    logic [2:0]        fire_idx;

    assign mask_ext = {3'd0, action_mask_reg};
    assign fire_idx = 3'(int'(click_cnt) - 1);

    always_comb begin
        logic [CNT_W-1:0] cnt;
        last_level_next = last_level_reg;
        press_ms_next   = press_ms_reg;
        press_rem_next  = press_rem_reg;
        idle_next       = idle_reg;
        wslot_next      = wslot_reg;
        for (int i = 0; i < SLOTS; i++) begin
            slot_next[i] = slot_reg[i];
        end
        press_push = 1'b0;

        if (in_valid_reg) begin
            if (in_dead) begin
                // Bounce blackout: only time passes
                press_ms_next  = ms_add;
                press_rem_next = rem_add;
            end else begin
                last_level_next = in_level_reg;
                if (!in_level_reg) begin
                    press_push     = press_zero;
                    press_ms_next  = ms_add;
                    press_rem_next = rem_add;
                    idle_next      = '0;
                end else begin
                    if (!press_zero) begin
                        slot_next[wslot_reg] = press_len;
                        wslot_next = (wslot_reg == SLOT_W'(SLOTS - 1)) ?
                                     '0 : SLOT_W'(wslot_reg + 1'b1);
                    end
                    idle_next      = idle_add;
                    press_ms_next  = '0;
                    press_rem_next = '0;
                end
            end
        end

        // Count valid presses over the updated ring
        cnt = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if ((slot_next[i] >= click_min_reg) && (slot_next[i] <= click_max_reg)) begin
                cnt = cnt + CNT_W'(1);
            end
        end
        click_cnt = cnt;

        flush = in_valid_reg && !in_dead &&
                (idle_next > IDLE_W'(idle_flush_reg)) && (slot_next[0] != '0);

        if (flush) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_next[i] = '0;
            end
            wslot_next = '0;
        end
    end

    // Assemble up to two result beats
    always_comb begin
        res0  = '{last: 1'b1, fire: 1'b0, count: 3'd0, kind: EV_DONE};
        res1  = '{last: 1'b1, fire: 1'b0, count: 3'd0, kind: EV_DONE};
        n_res = 2'd0;
        if (press_push) begin
            res0.kind = EV_PRESS;
            n_res     = 2'd1;
        end else if (flush && (click_cnt != '0)) begin
            res0.kind  = EV_CLICKS;
            res0.last  = 1'b0;
            res0.count = (int'(click_cnt) > 7) ? 3'd7 : 3'(click_cnt);
            res0.fire  = (int'(click_cnt) <= 5) && mask_ext[fire_idx];
            n_res      = 2'd2;
        end else if (flush) begin
            n_res = 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_level_reg <= 1'b1;
            press_ms_reg   <= '0;
            press_rem_reg  <= '0;
            idle_reg       <= '0;
            wslot_reg      <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                slot_reg[i] <= '0;
            end
        end else begin
            last_level_reg <= last_level_next;
            press_ms_reg   <= press_ms_next;
            press_rem_reg  <= press_rem_next;
            idle_reg       <= idle_next;
            wslot_reg      <= wslot_next;
            for (int i = 0; i < SLOTS; i++) begin
                slot_reg[i] <= slot_next[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    result_t           fifo_mem [FIFO_DEPTH];
    logic [FPTR_W-1:0] wptr_reg, rptr_reg;
    logic [FPTR_W-1:0] wptr_inc1, wptr_inc2, rptr_inc1;
    logic [FCNT_W-1:0] fifo_cnt_next;
    logic              m_pop;
    result_t           head;

    function automatic logic [FPTR_W-1:0] ptr_inc(input logic [FPTR_W-1:0] p);
        return (p == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : FPTR_W'(p + 1'b1);
    endfunction

    assign wptr_inc1 = ptr_inc(wptr_reg);
    assign wptr_inc2 = ptr_inc(wptr_inc1);
    assign rptr_inc1 = ptr_inc(rptr_reg);

    assign head     = fifo_mem[rptr_reg];
    assign m_tvalid = (fifo_cnt_reg != '0);
    assign m_tdata  = {2'b00, head.fire, head.count, head.kind};
    assign m_tlast  = head.last;
    assign m_pop    = m_tvalid && m_tready;

    assign fifo_cnt_next = fifo_cnt_reg + FCNT_W'(n_res) - FCNT_W'(m_pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg     <= '0;
            rptr_reg     <= '0;
            fifo_cnt_reg <= '0;
        end else begin
            fifo_cnt_reg <= fifo_cnt_next;
            if (m_pop) begin
                rptr_reg <= rptr_inc1;
            end
            case (n_res)
                2'd1:    wptr_reg <= wptr_inc1;
                2'd2:    wptr_reg <= wptr_inc2;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            fifo_mem[wptr_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            fifo_mem[wptr_inc1] <= res1;
        end
    end

endmodule

`default_nettype wire

### design/mcb_checker.sv
// ----------------------------------------------------------------------------
// mcb_checker
// Port-level checks on the result stream of the multi-click button detector.
// ----------------------------------------------------------------------------
`default_nettype none

`include "multi_click_button_detector_assert.svh"

module mcb_checker
    import mcb_pkg::*;
(
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast
);

    // Stalled beat holds
    `MCB_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")

    // Press-start and done beats close their tick and carry no count
    `MCB_ASSERT_NOW(a_plain, m_tvalid && (m_tdata[1:0] == EV_PRESS || m_tdata[1:0] == EV_DONE), m_tlast && (m_tdata[5:2] == 4'd0), "press or done beat malformed")

    // A click beat reports at least one click and is not marked last
    `MCB_ASSERT_NOW(a_clicks, m_tvalid && (m_tdata[1:0] == EV_CLICKS), !m_tlast && (m_tdata[4:2] != 3'd0), "click beat malformed")

    // Fire never set beyond five clicks
    `MCB_ASSERT_NOW(a_fire, m_tvalid && m_tdata[5], m_tdata[4:2] <= 3'd5, "action fired for count above five")

endmodule

bind multi_click_button_detector mcb_checker u_mcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
